/* hdl/mfilt_pkg.sv */
// Shared types, constants and compare helpers of the 3x3 median filter.
// Used by mfilt_linebuf, mfilt_median and median_filter_3x3; depends on nothing.
package mfilt_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 11;
	localparam int ROW_W     = 11;
	// Width for column positions compared against the active width
	localparam int POS_W     = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [SIZE_W-1:0]    FRAME_WIDTH_RST  = SIZE_W'(512);
	localparam logic [SIZE_W-1:0]    FRAME_HEIGHT_RST = SIZE_W'(512);

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_idx_t;

	typedef struct packed {
		logic command;
		pix_t pixel_in;
	} in_item_t;

	typedef struct packed {
		pix_t pixel_out;
		logic frame_last;
	} out_item_t;

	// One window column, sorted
	typedef struct packed {
		pix_t lo;
		pix_t md;
		pix_t hi;
	} col_t;

	// Line buffer access for one accepted item
	typedef struct packed {
		logic     en;
		col_idx_t col;
		pix_t     pix;
	} lb_req_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// Three compare-exchange steps
	function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
		pix_t lo1;
		pix_t hi1;
		pix_t t;
		col_t r;
		lo1  = min2(a, b);
		hi1  = max2(a, b);
		r.hi = max2(hi1, c);
		t    = min2(hi1, c);
		r.lo = min2(lo1, t);
		r.md = max2(lo1, t);
		return r;
	endfunction

endpackage

/* hdl/mfilt_linebuf.sv */
// Two-row line store of the median filter with registered reads.
// Depends on mfilt_pkg.
module mfilt_linebuf (
	input  logic              clk,
	input  mfilt_pkg::lb_req_t req,
	input  logic              adv,
	output mfilt_pkg::pix_t   top_s1,
	output mfilt_pkg::pix_t   mid_s1
);

	mfilt_pkg::pix_t     row_near [mfilt_pkg::MAX_WIDTH];
	mfilt_pkg::pix_t     row_far  [mfilt_pkg::MAX_WIDTH];
	mfilt_pkg::col_idx_t col_s1;
	logic                fwd;

	// Far row is written when the item leaves stage 1; bypass when the next item reads that column
	assign fwd = adv && (req.col == col_s1);

	// Near row: read old value and store the new pixel
	always_ff @(posedge clk) begin
		if (req.en) begin
			mid_s1            <= row_near[req.col];
			row_near[req.col] <= req.pix;
			col_s1            <= req.col;
		end
	end

	// Far row: takes the near row value of the item leaving stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			row_far[col_s1] <= mid_s1;
		end
		if (req.en) begin
			top_s1 <= fwd ? mid_s1 : row_far[req.col];
		end
	end

endmodule

/* hdl/mfilt_median.sv */
// Median of a 3x3 window held as three sorted columns.
// Depends on mfilt_pkg.
module mfilt_median (
	input  mfilt_pkg::col_t [2:0] cols,
	output mfilt_pkg::pix_t       med
);

	mfilt_pkg::pix_t lo_max;
	mfilt_pkg::pix_t md_med;
	mfilt_pkg::pix_t hi_min;

	// Max of lows, median of middles, min of highs, then their median
	always_comb begin
		lo_max = mfilt_pkg::max3(cols[0].lo, cols[1].lo, cols[2].lo);
		md_med = mfilt_pkg::med3(cols[0].md, cols[1].md, cols[2].md);
		hi_min = mfilt_pkg::min3(cols[0].hi, cols[1].hi, cols[2].hi);
		med    = mfilt_pkg::med3(lo_max, md_med, hi_min);
	end

endmodule

/* hdl/median_filter_3x3.sv */
// Top level of the 3x3 median filter: position control, window and result register.
// Depends on mfilt_pkg, mfilt_linebuf and mfilt_median.
//
// Usage:
//   src channel: one item per transfer, a pixel (command = pixel) in raster
//   order, or a flush tick. After a frame, send frame_width+1 flush ticks.
//   dst channel: one result per item from the second row's second pixel on,
//   in raster order; border pixels pass unchanged, frame_last marks the end.
//   cfg channel: cfg_ready is always high; index 0 = frame_width,
//   index 1 = frame_height. Write only while the block is idle.
// Pipeline: the item that completes a window passes the stage 1 line store read,
//   the stage 2 window and the result register, in that order.
// Throughput: one item per cycle while src_stall is low; the line store has one
//   read and one write per row memory per cycle, which sets that rate.
// Reset: positions, window and valid flags clear; sizes return to 512x512.
//   The line store is not cleared; unwritten entries only reach border or
//   discarded windows.
// Stall: the stage ahead of a stalled result keeps filling; src_stall rises
//   only when stages 1 and 2 and the result register are all occupied.
module median_filter_3x3 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  mfilt_pkg::in_item_t                 src_data,
	output logic                                dst_valid,
	input  logic                                dst_stall,
	output mfilt_pkg::out_item_t                dst_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mfilt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfilt_pkg::SIZE_W-1:0]        cfg_data
);

	// Configuration and positions
	logic [mfilt_pkg::SIZE_W-1:0] fw_q;
	logic [mfilt_pkg::SIZE_W-1:0] fh_q;
	logic [mfilt_pkg::POS_W-1:0]  w_act;
	logic [mfilt_pkg::SIZE_W-1:0] h_act;
	mfilt_pkg::col_idx_t          in_col_q;
	logic [mfilt_pkg::ROW_W-1:0]  in_row_q;
	mfilt_pkg::col_idx_t          out_col_q;
	logic [mfilt_pkg::ROW_W-1:0]  out_row_q;

	mfilt_pkg::col_idx_t          c_col;
	mfilt_pkg::col_idx_t          o_col;
	logic                         in_col_last;
	logic                         out_col_last;
	logic                         out_row_last;
	logic                         emit;
	logic                         border;
	logic                         last;
	mfilt_pkg::pix_t              pix;

	// Pipeline control
	logic                         accept;
	logic                         out_ready;
	logic                         s2_go;
	logic                         s2_free;
	logic                         s1_go;
	logic                         s1_free;

	logic                         v_s1;
	logic                         emit_s1;
	logic                         border_s1;
	logic                         last_s1;
	mfilt_pkg::pix_t              pix_s1;
	mfilt_pkg::pix_t              top_s1;
	mfilt_pkg::pix_t              mid_s1;

	logic                         v_s2;
	logic                         border_s2;
	logic                         last_s2;

	// Window: column 2 is the newest
	mfilt_pkg::col_t [2:0]        win_q;
	mfilt_pkg::pix_t              ctr_q;
	mfilt_pkg::pix_t              ctr_next_q;
	mfilt_pkg::pix_t              med;
	mfilt_pkg::lb_req_t           lb_req;

	// Handshake
	assign out_ready = !dst_valid || !dst_stall;
	assign s2_go     = v_s2 && out_ready;
	assign s2_free   = !v_s2 || out_ready;
	assign s1_go     = v_s1 && s2_free;
	assign s1_free   = !v_s1 || s2_free;
	assign accept    = src_valid && s1_free;
	assign src_stall = !s1_free;
	assign cfg_ready = 1'b1;

	// Active frame size
	always_comb begin
		priority if (fw_q == '0) begin
			w_act = mfilt_pkg::POS_W'(1);
		end else if (mfilt_pkg::POS_W'(fw_q) > mfilt_pkg::POS_W'(mfilt_pkg::MAX_WIDTH)) begin
			w_act = mfilt_pkg::POS_W'(mfilt_pkg::MAX_WIDTH);
		end else begin
			w_act = mfilt_pkg::POS_W'(fw_q);
		end
		h_act = (fh_q == '0) ? mfilt_pkg::SIZE_W'(1) : fh_q;
	end

	// Positions of the incoming item and of the result it completes
	always_comb begin
		if (mfilt_pkg::POS_W'(in_col_q) >= w_act) begin
			c_col = mfilt_pkg::COL_W'(w_act - mfilt_pkg::POS_W'(1));
		end else begin
			c_col = in_col_q;
		end
		if (mfilt_pkg::POS_W'(out_col_q) >= w_act) begin
			o_col = mfilt_pkg::COL_W'(w_act - mfilt_pkg::POS_W'(1));
		end else begin
			o_col = out_col_q;
		end
		in_col_last  = (mfilt_pkg::POS_W'(c_col) + mfilt_pkg::POS_W'(1)) >= w_act;
		out_col_last = (mfilt_pkg::POS_W'(o_col) + mfilt_pkg::POS_W'(1)) >= w_act;
		out_row_last = ({1'b0, out_row_q} + (mfilt_pkg::ROW_W + 1)'(1))
			>= (mfilt_pkg::ROW_W + 1)'(h_act);
		emit   = (in_row_q >= mfilt_pkg::ROW_W'(2))
			|| ((in_row_q == mfilt_pkg::ROW_W'(1)) && (c_col != '0));
		border = (out_row_q == '0) || out_row_last || (o_col == '0) || out_col_last;
		last   = out_row_last && out_col_last;
		pix    = (src_data.command == mfilt_pkg::CMD_FLUSH) ? '0 : src_data.pixel_in;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= mfilt_pkg::FRAME_WIDTH_RST;
			fh_q <= mfilt_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mfilt_pkg::REG_FRAME_WIDTH) begin
				fw_q <= cfg_data;
			end
			if (cfg_index == mfilt_pkg::REG_FRAME_HEIGHT) begin
				fh_q <= cfg_data;
			end
		end
	end

	// Position counters, advanced on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + mfilt_pkg::ROW_W'(1);
				end else begin
					in_col_q <= c_col + mfilt_pkg::COL_W'(1);
				end
				if (emit) begin
					if (out_col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + mfilt_pkg::ROW_W'(1);
					end else begin
						out_col_q <= o_col + mfilt_pkg::COL_W'(1);
					end
				end
			end
		end
	end

	// Line store
	always_comb begin
		lb_req.en  = accept;
		lb_req.col = c_col;
		lb_req.pix = pix;
	end

	mfilt_linebuf u_linebuf (
		.clk    (clk),
		.req    (lb_req),
		.adv    (s1_go),
		.top_s1 (top_s1),
		.mid_s1 (mid_s1)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			dst_valid <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= accept;
			end
			if (s1_go) begin
				v_s2 <= emit_s1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go) begin
				dst_valid <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid <= 1'b0;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last;
			pix_s1    <= pix;
		end
		if (s1_go) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
		if (s2_go) begin
			dst_data.pixel_out  <= border_s2 ? ctr_q : med;
			dst_data.frame_last <= last_s2;
		end
	end

	// Window shift: new column sorted on entry, centre kept unsorted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			ctr_q      <= '0;
			ctr_next_q <= '0;
		end else if (s1_go) begin
			win_q[0]   <= win_q[1];
			win_q[1]   <= win_q[2];
			win_q[2]   <= mfilt_pkg::sort3(top_s1, mid_s1, pix_s1);
			ctr_q      <= ctr_next_q;
			ctr_next_q <= mid_s1;
		end
	end

	mfilt_median u_median (
		.cols (win_q),
		.med  (med)
	);

`ifndef SYNTH
	// Full pipeline under a stalled result must hold off the source
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && dst_valid && dst_stall) |-> src_stall)
		else $error("source not stalled with full pipeline");

	// The frame's final result returns all positions to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && last) |=> (in_col_q == '0 && in_row_q == '0
			&& out_col_q == '0 && out_row_q == '0))
		else $error("positions not cleared after frame end");

	// A new result comes only from an occupied stage 2
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(v_s2))
		else $error("result without stage 2 item");

	// Stage 1 cannot advance into an occupied, stalled stage 2
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && dst_valid && dst_stall) |-> !s1_go)
		else $error("stage 1 overran stage 2");
`endif

endmodule
